### rtl/core/lkvt_pkg.sv
`default_nettype none

package lkvt_pkg;

   localparam int KEY_W     = 64;
   localparam int VAL_W     = 64;
   localparam int KEY_CHARS = 8;

   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_SET = 1'b1;
   localparam logic TBL_FLAG = 1'b0;
   localparam logic TBL_WORD = 1'b1;

   typedef struct packed {
      logic             func;
      logic             table_sel;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } req_item_type;

   typedef struct packed {
      logic [VAL_W-1:0] read_value;
      logic             found;
      logic             dropped;
   } rsp_item_type;

   // Sequencer steps
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HIT,
      ST_MISS,
      ST_EMIT
   } step_type;

   // Jump conditions
   typedef enum logic [2:0] {
      CND_NEVER,
      CND_ALWAYS,
      CND_REQ,
      CND_END,
      CND_HIT,
      CND_SLOT
   } cond_type;

   // Result to build in this step
   typedef enum logic [1:0] {
      RES_NONE,
      RES_HIT,
      RES_MISS
   } res_type;

   typedef struct packed {
      cond_type cond_a;
      step_type tgt_a;
      cond_type cond_b;
      step_type tgt_b;
      step_type tgt_else;
      logic     ready;
      logic     clr_idx;
      logic     inc_else;
      res_type  res_kind;
      logic     emit;
   } ucode_type;

   // Status of one table at the current scan slot
   typedef struct packed {
      logic at_end;
      logic hit;
      logic full;
   } store_stat_type;

   // Control from the sequencer to the datapath
   typedef struct packed {
      logic    capture;
      logic    emit;
      res_type res_kind;
      logic    wr;
      logic    append;
   } seq_ctl_type;

   // Control store: one word per step
   function automatic ucode_type ucode_rom(step_type s);
      ucode_type uc;
      uc.cond_a   = CND_NEVER;
      uc.tgt_a    = ST_IDLE;
      uc.cond_b   = CND_NEVER;
      uc.tgt_b    = ST_IDLE;
      uc.tgt_else = ST_IDLE;
      uc.ready    = 1'b0;
      uc.clr_idx  = 1'b0;
      uc.inc_else = 1'b0;
      uc.res_kind = RES_NONE;
      uc.emit     = 1'b0;
      unique case (s)
         ST_IDLE: begin
            uc.cond_a   = CND_REQ;
            uc.tgt_a    = ST_SCAN;
            uc.tgt_else = ST_IDLE;
            uc.ready    = 1'b1;
            uc.clr_idx  = 1'b1;
         end
         ST_SCAN: begin
            uc.cond_a   = CND_END;
            uc.tgt_a    = ST_MISS;
            uc.cond_b   = CND_HIT;
            uc.tgt_b    = ST_HIT;
            uc.tgt_else = ST_SCAN;
            uc.inc_else = 1'b1;
         end
         ST_HIT: begin
            uc.cond_a   = CND_ALWAYS;
            uc.tgt_a    = ST_EMIT;
            uc.res_kind = RES_HIT;
         end
         ST_MISS: begin
            uc.cond_a   = CND_ALWAYS;
            uc.tgt_a    = ST_EMIT;
            uc.res_kind = RES_MISS;
         end
         ST_EMIT: begin
            uc.cond_a   = CND_SLOT;
            uc.tgt_a    = ST_IDLE;
            uc.tgt_else = ST_EMIT;
            uc.emit     = 1'b1;
         end
         default: begin
            uc.cond_a = CND_ALWAYS;
            uc.tgt_a  = ST_IDLE;
         end
      endcase
      return uc;
   endfunction

   // Cut the key at its first zero byte and after nbytes characters
   function automatic logic [KEY_W-1:0] norm_key(logic [KEY_W-1:0] k, int nbytes);
      logic [KEY_W-1:0] r;
      logic             keep;
      r    = '0;
      keep = 1'b1;
      for (int i = 0; i < KEY_CHARS; i++) begin
         if (k[8*i +: 8] == 8'h00 || i >= nbytes) begin
            keep = 1'b0;
         end
         if (keep) begin
            r[8*i +: 8] = k[8*i +: 8];
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/core/lkvt_store.sv
`default_nettype none

module lkvt_store #(
   parameter int DEPTH = 64,
   parameter int VAL_W = 64,
   parameter int IDX_W = 7
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [IDX_W-1:0]            idx,
   input  wire logic [IDX_W-1:0]            rd_idx,
   input  wire logic [lkvt_pkg::KEY_W-1:0]  key,
   input  wire logic [VAL_W-1:0]            wr_value,
   input  wire logic                        wr,
   input  wire logic                        append,
   output lkvt_pkg::store_stat_type         stat,
   output logic      [VAL_W-1:0]            rd_value
);

   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int ROW_W = lkvt_pkg::KEY_W + VAL_W;

   logic [ROW_W-1:0] store_mem [DEPTH];
   logic [ROW_W-1:0] rd_ff;
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    count_in;

   // Write the row at the scan slot; read the slot the scan looks at next
   always_ff @(posedge clock) begin
      if (wr) begin
         store_mem[idx[AW-1:0]] <= {key, wr_value};
      end
      rd_ff <= store_mem[rd_idx[AW-1:0]];
   end

   // Used slots are always a prefix of the table: track its length
   always_comb begin
      count_in = count_ff;
      if (append) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign stat = '{at_end: (idx == IDX_W'(count_ff)),
                   hit:    (rd_ff[ROW_W-1 -: lkvt_pkg::KEY_W] == key),
                   full:   (count_ff == CW'(DEPTH))};
   assign rd_value = rd_ff[VAL_W-1:0];

endmodule

`default_nettype wire

### rtl/core/lkvt_seq.sv
`default_nettype none

module lkvt_seq #(
   parameter int IDX_W = 7
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     item_set,
   input  wire lkvt_pkg::store_stat_type stat,
   input  wire logic                     slot_free,
   output lkvt_pkg::seq_ctl_type         ctl,
   output logic      [IDX_W-1:0]         idx,
   output logic      [IDX_W-1:0]         idx_next
);

   lkvt_pkg::step_type  step_ff;
   lkvt_pkg::step_type  step_in;
   lkvt_pkg::ucode_type uc;
   logic [IDX_W-1:0]    idx_ff;
   logic [IDX_W-1:0]    idx_in;
   logic                take_a;
   logic                take_b;

   function automatic logic cond_met(lkvt_pkg::cond_type c, logic rv,
                                     lkvt_pkg::store_stat_type st, logic sf);
      logic r;
      unique case (c)
         lkvt_pkg::CND_NEVER:  r = 1'b0;
         lkvt_pkg::CND_ALWAYS: r = 1'b1;
         lkvt_pkg::CND_REQ:    r = rv;
         lkvt_pkg::CND_END:    r = st.at_end;
         lkvt_pkg::CND_HIT:    r = st.hit;
         lkvt_pkg::CND_SLOT:   r = sf;
         default:              r = 1'b0;
      endcase
      return r;
   endfunction

   // Fetch the control word of the current step
   assign uc = lkvt_pkg::ucode_rom(step_ff);

   // Next step: first jump, second jump, else fall through
   always_comb begin
      take_a = cond_met(uc.cond_a, req_valid, stat, slot_free);
      take_b = cond_met(uc.cond_b, req_valid, stat, slot_free);
      priority if (take_a) begin
         step_in = uc.tgt_a;
      end else if (take_b) begin
         step_in = uc.tgt_b;
      end else begin
         step_in = uc.tgt_else;
      end
   end

   // Scan index: clear on entry, advance while no jump is taken
   always_comb begin
      priority if (uc.clr_idx) begin
         idx_in = '0;
      end else if (uc.inc_else && !take_a && !take_b) begin
         idx_in = idx_ff + IDX_W'(1);
      end else begin
         idx_in = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= lkvt_pkg::ST_IDLE;
         idx_ff  <= '0;
      end else begin
         step_ff <= step_in;
         idx_ff  <= idx_in;
      end
   end

   // Decode datapath control
   always_comb begin
      ctl.capture  = uc.ready && req_valid;
      ctl.emit     = uc.emit && slot_free;
      ctl.res_kind = uc.res_kind;
      ctl.wr       = item_set &&
                     (uc.res_kind == lkvt_pkg::RES_HIT ||
                      (uc.res_kind == lkvt_pkg::RES_MISS && !stat.full));
      ctl.append   = item_set && uc.res_kind == lkvt_pkg::RES_MISS && !stat.full;
      req_stall    = !uc.ready;
   end

   assign idx      = idx_ff;
   assign idx_next = idx_in;

endmodule

`default_nettype wire

### rtl/core/linear_key_value_table_unit.sv
`default_nettype none

// Channel  Direction  Ports                          Item
// -------  ---------  -----------------------------  ---------------------------------
// req      in         req_valid, req_stall, req_item func, table_sel, key, value
// rsp      out        rsp_valid, rsp_stall, rsp_item read_value, found, dropped
//
// An item passes through accept, the scan steps, result and hand-off; the scan stops at
// the slot of the first match, or at the used-slot count when none matches (at most
// FLAG_SLOTS or WORD_SLOTS); the scan reads one slot a cycle from the table memory.
// One item is in work at a time; the next is taken while a result waits in rsp.
// Reset clears the sequencer and both fill counts; no clearing pass.
// A stalled rsp holds its item; the sequencer waits at hand-off until it drains.

module linear_key_value_table_unit #(
   parameter int FLAG_SLOTS = 64,
   parameter int WORD_SLOTS = 64,
   parameter int KEY_BYTES  = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire lkvt_pkg::req_item_type req_item,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output lkvt_pkg::rsp_item_type     rsp_item
);

   localparam int MAX_SLOTS = (FLAG_SLOTS > WORD_SLOTS) ? FLAG_SLOTS : WORD_SLOTS;
   localparam int IDX_W     = $clog2(MAX_SLOTS + 1);

   lkvt_pkg::req_item_type   item_ff;
   lkvt_pkg::req_item_type   item_in;
   lkvt_pkg::rsp_item_type   res_ff;
   lkvt_pkg::rsp_item_type   res_in;
   lkvt_pkg::rsp_item_type   rsp_item_ff;
   lkvt_pkg::rsp_item_type   rsp_item_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;

   lkvt_pkg::seq_ctl_type    ctl;
   lkvt_pkg::store_stat_type flag_stat;
   lkvt_pkg::store_stat_type word_stat;
   lkvt_pkg::store_stat_type sel_stat;
   logic [IDX_W-1:0]         idx;
   logic [IDX_W-1:0]         idx_next;
   logic                     slot_free;
   logic                     item_set;
   logic                     flag_wr;
   logic                     word_wr;
   logic                     flag_append;
   logic                     word_append;
   logic                     flag_rd;
   logic [lkvt_pkg::VAL_W-1:0] word_rd;
   logic [lkvt_pkg::VAL_W-1:0] sel_value;

   assign item_set  = (item_ff.func == lkvt_pkg::FUNC_SET);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Capture the item with its key normalized
   always_comb begin
      item_in = item_ff;
      if (ctl.capture) begin
         item_in     = req_item;
         item_in.key = lkvt_pkg::norm_key(req_item.key, KEY_BYTES);
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   lkvt_seq #(
      .IDX_W (IDX_W)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .item_set  (item_set),
      .stat      (sel_stat),
      .slot_free (slot_free),
      .ctl       (ctl),
      .idx       (idx),
      .idx_next  (idx_next)
   );

   // Steer writes to the selected table
   assign flag_wr     = ctl.wr && item_ff.table_sel == lkvt_pkg::TBL_FLAG;
   assign word_wr     = ctl.wr && item_ff.table_sel == lkvt_pkg::TBL_WORD;
   assign flag_append = ctl.append && item_ff.table_sel == lkvt_pkg::TBL_FLAG;
   assign word_append = ctl.append && item_ff.table_sel == lkvt_pkg::TBL_WORD;

   lkvt_store #(
      .DEPTH (FLAG_SLOTS),
      .VAL_W (1),
      .IDX_W (IDX_W)
   ) u_flag_store (
      .clock    (clock),
      .reset    (reset),
      .idx      (idx),
      .rd_idx   (idx_next),
      .key      (item_ff.key),
      .wr_value (item_ff.value[0]),
      .wr       (flag_wr),
      .append   (flag_append),
      .stat     (flag_stat),
      .rd_value (flag_rd)
   );

   lkvt_store #(
      .DEPTH (WORD_SLOTS),
      .VAL_W (lkvt_pkg::VAL_W),
      .IDX_W (IDX_W)
   ) u_word_store (
      .clock    (clock),
      .reset    (reset),
      .idx      (idx),
      .rd_idx   (idx_next),
      .key      (item_ff.key),
      .wr_value (item_ff.value),
      .wr       (word_wr),
      .append   (word_append),
      .stat     (word_stat),
      .rd_value (word_rd)
   );

   // Select status and data of the addressed table
   always_comb begin
      if (item_ff.table_sel == lkvt_pkg::TBL_WORD) begin
         sel_stat  = word_stat;
         sel_value = word_rd;
      end else begin
         sel_stat  = flag_stat;
         sel_value = {{(lkvt_pkg::VAL_W-1){1'b0}}, flag_rd};
      end
   end

   // Build the result
   always_comb begin
      res_in = res_ff;
      unique case (ctl.res_kind)
         lkvt_pkg::RES_HIT: begin
            res_in.read_value = item_set ? '0 : sel_value;
            res_in.found      = !item_set;
            res_in.dropped    = 1'b0;
         end
         lkvt_pkg::RES_MISS: begin
            res_in.read_value = '0;
            res_in.found      = 1'b0;
            res_in.dropped    = item_set && sel_stat.full;
         end
         default: begin
            res_in = res_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   // Output register: load on hand-off, drop when taken
   always_comb begin
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (ctl.emit) begin
         rsp_item_in  = res_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_one_table_wr: assert property (@(posedge clock) disable iff (reset)
      !(flag_wr && word_wr))
      else $error("both tables written in one cycle");

   a_emit_fills: assert property (@(posedge clock) disable iff (reset)
      ctl.emit |=> rsp_valid)
      else $error("hand-off did not fill the output register");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second item taken while one is in work");

   a_found_xor_dropped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_item.found && rsp_item.dropped))
      else $error("result both found and dropped");

endmodule

`default_nettype wire
